// File: rtl/jpdt_pkg.sv
// ----------------------------------------------------------------------------
// jpdt_pkg
// Shared constants for the joint PD torque controller with limit repulsion.
// ----------------------------------------------------------------------------
package jpdt_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] CFG_KP_GAIN          = 3'd0;
    localparam logic [2:0] CFG_KD_GAIN          = 3'd1;
    localparam logic [2:0] CFG_INV_PERIOD       = 3'd2;
    localparam logic [2:0] CFG_LIMIT_MARGIN     = 3'd3;
    localparam logic [2:0] CFG_INV_LIMIT_MARGIN = 3'd4;
    localparam logic [2:0] CFG_TORQUE_MODE      = 3'd5;

    // Register values after reset.
    localparam logic [31:0] RST_KP_GAIN          = 32'd65536000;
    localparam logic [31:0] RST_KD_GAIN          = 32'd65536000;
    localparam logic [31:0] RST_INV_PERIOD       = 32'd32768000;
    localparam logic [30:0] RST_LIMIT_MARGIN     = 31'd4575;
    localparam logic [31:0] RST_INV_LIMIT_MARGIN = 32'd938744;
    localparam logic        RST_TORQUE_MODE      = 1'b0;

    // Limit zone codes.
    localparam logic [1:0] ZONE_NONE  = 2'd0;
    localparam logic [1:0] ZONE_UPPER = 2'd1;
    localparam logic [1:0] ZONE_LOWER = 2'd2;

    // Torque mode codes.
    localparam logic MODE_COMPUTED = 1'b0;

    // Every product magnitude is clamped to this value.
    localparam logic [47:0] PSAT = 48'hFFFF_FFFF_FFFF;

    // Saturation rails of the torque output.
    localparam logic [31:0] TORQUE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] TORQUE_MIN = 32'h8000_0000;

    // Number of register stages from input acceptance to the output register.
    localparam int STAGES = 9;

    // Stream widths.
    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;

endpackage

// File: rtl/joint_pd_torque_with_limit_avoid_top.sv
// ----------------------------------------------------------------------------
// joint_pd_torque_with_limit_avoid_top
// Pipelined joint PD torque controller with joint-limit repulsion, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Joint samples arrive on the s_axis channel, one per transfer, with the
//   joint index in tuser. Each sample produces exactly one result transfer on
//   m_axis, in order: saturated torque, the reference angle passed through,
//   the limit zone and a saturation flag.
//   The cfg channel writes the gain, period, margin and mode registers. It is
//   always ready and must only be used while no sample is in flight.
//   Throughput is one sample per cycle while m_axis_tready is held high; the
//   pipeline depth is set by the chain of multipliers (the derivative gain
//   acts on a product, and the wide products are split into two partial
//   products that are summed one stage later).
//   The previous reference angle of each joint lives in a one-write,
//   one-read memory that is read and written on the accepting edge, so
//   back-to-back samples of one joint see each other without forwarding.
//   Reset clears all valid bits, the per-joint "seen" flags and the
//   registers to their defaults; the memory needs no clearing pass.
//   When the receiver holds m_axis_tready low, each stage keeps its item and
//   empty stages still fill, so s_axis_tready only drops once all nine stages
//   are occupied.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_limit_avoid_top #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // angle_ref[31:0], angle_meas[63:32], velocity_meas[95:64],
    // upper_limit[127:96], lower_limit[159:128], peak_torque[190:160],
    // limb_active[191]
    input  logic [jpdt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // joint_index[5:0]
    input  logic [jpdt_pkg::IN_USER_W-1:0]   s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // torque_out[31:0], angle_out[63:32], limit_zone[65:64], saturated[66],
    // zero fill[71:67]
    output logic [jpdt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jpdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int EW = (JW > jpdt_pkg::IN_USER_W) ? JW : jpdt_pkg::IN_USER_W;
    localparam int CW = EW + 1;
    localparam int NS = jpdt_pkg::STAGES;

    // Stage payloads.
    typedef struct packed {
        logic [31:0] ang_ref;
        logic [31:0] ang_meas;
        logic [31:0] vel_meas;
        logic [31:0] upper_lim;
        logic [31:0] lower_lim;
        logic [30:0] peak;
        logic        active;
        logic        seen;
    } s1_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [31:0] vel_meas;
        logic [31:0] vmag;
        logic        vneg;
        logic [31:0] emag;
        logic        eneg;
        logic [30:0] peak;
        logic [1:0]  zone;
        logic [32:0] lim_dist;
        logic        active;
    } s2_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [31:0] vel_meas;
        logic [47:0] vref_mag;
        logic        vneg;
        logic [47:0] kpt;
        logic        eneg;
        logic [46:0] gain;
        logic [1:0]  zone;
        logic [32:0] lim_dist;
        logic        active;
    } s3_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [49:0] ev;
        logic [47:0] kpt;
        logic        eneg;
        logic [55:0] rh;
        logic [56:0] rl;
        logic [1:0]  zone;
        logic        active;
    } s4_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [47:0] kdmag;
        logic        kdneg;
        logic [47:0] kpt;
        logic        eneg;
        logic [47:0] rep;
        logic [1:0]  zone;
        logic        active;
    } s5_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [55:0] kh;
        logic [55:0] kl;
        logic        kdneg;
        logic [47:0] kpt;
        logic        eneg;
        logic [47:0] rep;
        logic [1:0]  zone;
        logic        active;
    } s6_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [47:0] kdt;
        logic        kdneg;
        logic [47:0] kpt;
        logic        eneg;
        logic [47:0] rep;
        logic [1:0]  zone;
        logic        active;
    } s7_t;

    typedef struct packed {
        logic [31:0] ang_ref;
        logic [50:0] u;
        logic [1:0]  zone;
        logic        active;
    } s8_t;

    // Configuration registers.
    logic [31:0] kp_gain_reg;
    logic [31:0] kd_gain_reg;
    logic [31:0] inv_period_reg;
    logic [30:0] limit_margin_reg;
    logic [31:0] inv_limit_margin_reg;
    logic        torque_mode_reg;

    // Handshake and per-joint state.
    logic [NS-1:0]         vld_reg;
    logic [NS-1:0]         adv;
    logic                  in_xfer;
    logic [CW-1:0]         idx_cmp;
    logic                  in_range;
    logic [JW-1:0]         addr;
    logic [MAX_JOINTS-1:0] seen_reg;
    logic [31:0]           prev_mem [0:MAX_JOINTS-1];
    logic [31:0]           prev_rd_reg;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;

    logic [31:0] torque_reg, torque_next;
    logic [31:0] angle_reg;
    logic [1:0]  zone_reg, zone_next;
    logic        sat_reg, sat_next;

    // ------------------------------------------------------------------------
    // Configuration channel
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg          <= jpdt_pkg::RST_KP_GAIN;
            kd_gain_reg          <= jpdt_pkg::RST_KD_GAIN;
            inv_period_reg       <= jpdt_pkg::RST_INV_PERIOD;
            limit_margin_reg     <= jpdt_pkg::RST_LIMIT_MARGIN;
            inv_limit_margin_reg <= jpdt_pkg::RST_INV_LIMIT_MARGIN;
            torque_mode_reg      <= jpdt_pkg::RST_TORQUE_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jpdt_pkg::CFG_KP_GAIN:          kp_gain_reg          <= cfg_data;
                jpdt_pkg::CFG_KD_GAIN:          kd_gain_reg          <= cfg_data;
                jpdt_pkg::CFG_INV_PERIOD:       inv_period_reg       <= cfg_data;
                jpdt_pkg::CFG_LIMIT_MARGIN:     limit_margin_reg     <= cfg_data[30:0];
                jpdt_pkg::CFG_INV_LIMIT_MARGIN: inv_limit_margin_reg <= cfg_data;
                jpdt_pkg::CFG_TORQUE_MODE:      torque_mode_reg      <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its item moves
    // on, so bubbles close up while the output is stalled.
    // ------------------------------------------------------------------------
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Per-joint state. The memory reads the old entry and writes the new one
    // on the same accepting edge, which orders samples of one joint exactly.
    // ------------------------------------------------------------------------
    assign idx_cmp  = CW'(s_axis_tuser);
    assign in_range = idx_cmp < CW'(MAX_JOINTS);
    assign addr     = idx_cmp[JW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_range)
        begin
            prev_mem[addr] <= s_axis_tdata[31:0];
        end
        if (adv[0])
        begin
            prev_rd_reg <= prev_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (in_xfer && in_range)
        begin
            seen_reg[addr] <= 1'b1;
        end
    end

    // Stage 1: unpack the sample.
    always_comb
    begin
        s1_next.ang_ref   = s_axis_tdata[31:0];
        s1_next.ang_meas  = s_axis_tdata[63:32];
        s1_next.vel_meas  = s_axis_tdata[95:64];
        s1_next.upper_lim = s_axis_tdata[127:96];
        s1_next.lower_lim = s_axis_tdata[159:128];
        s1_next.peak      = s_axis_tdata[190:160];
        s1_next.active    = s_axis_tdata[191];
        s1_next.seen      = in_range && seen_reg[addr];
    end

    // Stage 2: differences, magnitudes and the limit zone tests.
    always_comb
    begin
        logic [32:0] dv;
        logic [32:0] de;
        logic [33:0] d_up;
        logic [33:0] d_lo;
        logic [33:0] q_x;
        logic [33:0] m_x;

        dv   = {s1_reg.ang_ref[31], s1_reg.ang_ref} - {prev_rd_reg[31], prev_rd_reg};
        de   = {s1_reg.ang_meas[31], s1_reg.ang_meas}
             - {s1_reg.ang_ref[31], s1_reg.ang_ref};
        q_x  = {{2{s1_reg.ang_meas[31]}}, s1_reg.ang_meas};
        m_x  = {3'b000, limit_margin_reg};
        d_up = q_x + m_x - {{2{s1_reg.upper_lim[31]}}, s1_reg.upper_lim};
        d_lo = {{2{s1_reg.lower_lim[31]}}, s1_reg.lower_lim} + m_x - q_x;

        s2_next.ang_ref  = s1_reg.ang_ref;
        s2_next.vel_meas = s1_reg.vel_meas;
        s2_next.peak     = s1_reg.peak;
        s2_next.active   = s1_reg.active;

        // A joint's first sample has zero reference velocity.
        s2_next.vneg = dv[32];
        if (!s1_reg.seen)
        begin
            s2_next.vmag = '0;
        end
        else if (dv[32])
        begin
            s2_next.vmag = 32'(~dv + 33'd1);
        end
        else
        begin
            s2_next.vmag = dv[31:0];
        end

        s2_next.eneg = de[32];
        s2_next.emag = de[32] ? 32'(~de + 33'd1) : de[31:0];

        // The upper zone wins when both limits are within the margin.
        if (!d_up[33])
        begin
            s2_next.zone     = jpdt_pkg::ZONE_UPPER;
            s2_next.lim_dist = d_up[32:0];
        end
        else if (!d_lo[33])
        begin
            s2_next.zone     = jpdt_pkg::ZONE_LOWER;
            s2_next.lim_dist = d_lo[32:0];
        end
        else
        begin
            s2_next.zone     = jpdt_pkg::ZONE_NONE;
            s2_next.lim_dist = '0;
        end
    end

    // Stage 3: reference velocity, position term and repulsion gain products.
    always_comb
    begin
        logic [63:0] pv;
        logic [63:0] pe;
        logic [62:0] pg;

        pv = s2_reg.vmag * inv_period_reg;
        pe = s2_reg.emag * kp_gain_reg;
        pg = s2_reg.peak * inv_limit_margin_reg;

        s3_next.ang_ref  = s2_reg.ang_ref;
        s3_next.vel_meas = s2_reg.vel_meas;
        s3_next.vref_mag = pv[63:16];
        s3_next.vneg     = s2_reg.vneg;
        s3_next.kpt      = pe[63:16];
        s3_next.eneg     = s2_reg.eneg;
        s3_next.gain     = pg[62:16];
        s3_next.zone     = s2_reg.zone;
        s3_next.lim_dist = s2_reg.lim_dist;
        s3_next.active   = s2_reg.active;
    end

    // Stage 4: velocity error and the two halves of the repulsion product.
    always_comb
    begin
        logic [49:0] dq_x;
        logic [49:0] vr_x;

        dq_x = {{18{s3_reg.vel_meas[31]}}, s3_reg.vel_meas};
        vr_x = {2'b00, s3_reg.vref_mag};

        s4_next.ang_ref = s3_reg.ang_ref;
        s4_next.ev      = s3_reg.vneg ? (dq_x + vr_x) : (dq_x - vr_x);
        s4_next.kpt     = s3_reg.kpt;
        s4_next.eneg    = s3_reg.eneg;
        s4_next.rh      = s3_reg.gain[46:24] * s3_reg.lim_dist;
        s4_next.rl      = s3_reg.gain[23:0] * s3_reg.lim_dist;
        s4_next.zone    = s3_reg.zone;
        s4_next.active  = s3_reg.active;
    end

    // Stage 5: clamp the velocity error and finish the repulsion term.
    always_comb
    begin
        logic [49:0] ev_abs;
        logic [80:0] rfull;

        ev_abs = s4_reg.ev[49] ? (~s4_reg.ev + 50'd1) : s4_reg.ev;
        rfull  = {1'b0, s4_reg.rh, 24'b0} + {24'b0, s4_reg.rl};

        s5_next.ang_ref = s4_reg.ang_ref;
        s5_next.kdmag   = (|ev_abs[49:48]) ? jpdt_pkg::PSAT : ev_abs[47:0];
        s5_next.kdneg   = s4_reg.ev[49];
        s5_next.kpt     = s4_reg.kpt;
        s5_next.eneg    = s4_reg.eneg;
        s5_next.rep     = (|rfull[80:64]) ? jpdt_pkg::PSAT : rfull[63:16];
        s5_next.zone    = s4_reg.zone;
        s5_next.active  = s4_reg.active;
    end

    // Stage 6: the two halves of the damping product.
    always_comb
    begin
        s6_next.ang_ref = s5_reg.ang_ref;
        s6_next.kh      = s5_reg.kdmag[47:24] * kd_gain_reg;
        s6_next.kl      = s5_reg.kdmag[23:0] * kd_gain_reg;
        s6_next.kdneg   = s5_reg.kdneg;
        s6_next.kpt     = s5_reg.kpt;
        s6_next.eneg    = s5_reg.eneg;
        s6_next.rep     = s5_reg.rep;
        s6_next.zone    = s5_reg.zone;
        s6_next.active  = s5_reg.active;
    end

    // Stage 7: combine and clamp the damping product.
    always_comb
    begin
        logic [80:0] kfull;

        kfull = {1'b0, s6_reg.kh, 24'b0} + {25'b0, s6_reg.kl};

        s7_next.ang_ref = s6_reg.ang_ref;
        s7_next.kdt     = (|kfull[80:64]) ? jpdt_pkg::PSAT : kfull[63:16];
        s7_next.kdneg   = s6_reg.kdneg;
        s7_next.kpt     = s6_reg.kpt;
        s7_next.eneg    = s6_reg.eneg;
        s7_next.rep     = s6_reg.rep;
        s7_next.zone    = s6_reg.zone;
        s7_next.active  = s6_reg.active;
    end

    // Stage 8: signed sum of the three terms. Both PD terms enter negated.
    always_comb
    begin
        logic [50:0] kp_x;
        logic [50:0] kd_x;
        logic [50:0] rp_x;
        logic [50:0] t_kp;
        logic [50:0] t_kd;
        logic [50:0] t_rp;

        kp_x = {3'b000, s7_reg.kpt};
        kd_x = {3'b000, s7_reg.kdt};
        rp_x = {3'b000, s7_reg.rep};
        t_kp = s7_reg.eneg  ? kp_x : (~kp_x + 51'd1);
        t_kd = s7_reg.kdneg ? kd_x : (~kd_x + 51'd1);
        if (s7_reg.zone == jpdt_pkg::ZONE_UPPER)
        begin
            t_rp = ~rp_x + 51'd1;
        end
        else if (s7_reg.zone == jpdt_pkg::ZONE_LOWER)
        begin
            t_rp = rp_x;
        end
        else
        begin
            t_rp = '0;
        end

        s8_next.ang_ref = s7_reg.ang_ref;
        s8_next.u       = t_kp + t_kd + t_rp;
        s8_next.zone    = s7_reg.zone;
        s8_next.active  = s7_reg.active;
    end

    // Output stage: saturate to 32 bits and zero the result when the limb is
    // inactive or the block is in reference torque mode.
    always_comb
    begin
        logic enable;

        enable = s8_reg.active && (torque_mode_reg == jpdt_pkg::MODE_COMPUTED);

        if (!enable)
        begin
            torque_next = '0;
            sat_next    = 1'b0;
            zone_next   = jpdt_pkg::ZONE_NONE;
        end
        else
        begin
            zone_next = s8_reg.zone;
            if (!s8_reg.u[50] && (|s8_reg.u[49:31]))
            begin
                torque_next = jpdt_pkg::TORQUE_MAX;
                sat_next    = 1'b1;
            end
            else if (s8_reg.u[50] && !(&s8_reg.u[49:31]))
            begin
                torque_next = jpdt_pkg::TORQUE_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                torque_next = s8_reg.u[31:0];
                sat_next    = 1'b0;
            end
        end
    end

    // Payload registers, loaded whenever their stage advances.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= s1_next;
        end
        if (adv[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
        if (adv[3])
        begin
            s4_reg <= s4_next;
        end
        if (adv[4])
        begin
            s5_reg <= s5_next;
        end
        if (adv[5])
        begin
            s6_reg <= s6_next;
        end
        if (adv[6])
        begin
            s7_reg <= s7_next;
        end
        if (adv[7])
        begin
            s8_reg <= s8_next;
        end
        if (adv[8])
        begin
            torque_reg <= torque_next;
            angle_reg  <= s8_reg.ang_ref;
            zone_reg   <= zone_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {5'b00000, sat_reg, zone_reg, angle_reg, torque_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && sat_reg) |->
            (torque_reg == jpdt_pkg::TORQUE_MAX || torque_reg == jpdt_pkg::TORQUE_MIN))
        else $error("saturated result is not on a torque rail");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg & $past(seen_reg)) == $past(seen_reg))
        else $error("a joint seen flag was cleared outside reset");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> vld_reg[0])
        else $error("accepted sample did not enter the first stage");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg))
        else $error("input stalled while a pipeline stage was empty");

endmodule

// File: tb/jpdt_tb_pkg.sv
// ----------------------------------------------------------------------------
// jpdt_tb_pkg
// Sample and result types plus the scoreboard for the joint torque testbench.
// ----------------------------------------------------------------------------
package jpdt_tb_pkg;

    localparam int JOINT_COUNT  = 64;
    localparam int REPORT_LIMIT = 40;

    // One joint sample as it travels on the input stream.
    typedef struct {
        logic [5:0]         joint;
        logic signed [31:0] angle_ref;
        logic signed [31:0] angle_meas;
        logic signed [31:0] velocity_meas;
        logic signed [31:0] upper_limit;
        logic signed [31:0] lower_limit;
        logic [30:0]        peak_torque;
        logic               limb_active;
    } joint_sample_t;

    // One torque command as it leaves on the output stream.
    typedef struct {
        logic [31:0] torque;
        logic [31:0] angle;
        logic [1:0]  zone;
        logic        saturated;
    } torque_result_t;

    class torque_scoreboard;

        torque_result_t     pending_results[$];
        int                 mismatch_count;
        logic signed [31:0] prev_ref [JOINT_COUNT];
        bit                 joint_seen [JOINT_COUNT];
        longint             kp_gain;
        longint             kd_gain;
        longint             inv_period;
        longint             limit_margin;
        longint             inv_limit_margin;
        logic               torque_mode;

        function new();
            mismatch_count   = 0;
            kp_gain          = longint'(jpdt_pkg::RST_KP_GAIN);
            kd_gain          = longint'(jpdt_pkg::RST_KD_GAIN);
            inv_period       = longint'(jpdt_pkg::RST_INV_PERIOD);
            limit_margin     = longint'(jpdt_pkg::RST_LIMIT_MARGIN);
            inv_limit_margin = longint'(jpdt_pkg::RST_INV_LIMIT_MARGIN);
            torque_mode      = jpdt_pkg::RST_TORQUE_MODE;
            foreach (prev_ref[i])
            begin
                prev_ref[i]   = '0;
                joint_seen[i] = 1'b0;
            end
        endfunction

        // Q16.16 product on clamped magnitudes, truncated toward zero.
        function longint fx_mul(longint a, longint b);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] prod;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            if (ma > 64'(jpdt_pkg::PSAT))
                ma = 64'(jpdt_pkg::PSAT);
            if (mb > 64'(jpdt_pkg::PSAT))
                mb = 64'(jpdt_pkg::PSAT);
            prod = {64'd0, ma} * {64'd0, mb};
            prod = prod >> 16;
            if (prod > {80'd0, jpdt_pkg::PSAT})
                prod = {80'd0, jpdt_pkg::PSAT};
            return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function void store_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                jpdt_pkg::CFG_KP_GAIN:          kp_gain          = longint'(data);
                jpdt_pkg::CFG_KD_GAIN:          kd_gain          = longint'(data);
                jpdt_pkg::CFG_INV_PERIOD:       inv_period       = longint'(data);
                jpdt_pkg::CFG_LIMIT_MARGIN:     limit_margin     = longint'(data[30:0]);
                jpdt_pkg::CFG_INV_LIMIT_MARGIN: inv_limit_margin = longint'(data);
                jpdt_pkg::CFG_TORQUE_MODE:      torque_mode      = data[0];
                default: ;
            endcase
        endfunction

        // Works out the torque command for an accepted sample and queues it.
        function void note_sample(joint_sample_t s);
            longint         ref_a;
            longint         q;
            longint         dq;
            longint         up;
            longint         lo;
            longint         vref;
            longint         gain;
            longint         u;
            torque_result_t r;
            ref_a = s.angle_ref;
            q     = s.angle_meas;
            dq    = s.velocity_meas;
            up    = s.upper_limit;
            lo    = s.lower_limit;
            vref  = 0;
            if (joint_seen[s.joint])
                vref = fx_mul(ref_a - longint'(prev_ref[s.joint]), inv_period);
            prev_ref[s.joint]   = s.angle_ref;
            joint_seen[s.joint] = 1'b1;

            r.torque    = '0;
            r.angle     = s.angle_ref;
            r.zone      = jpdt_pkg::ZONE_NONE;
            r.saturated = 1'b0;
            if (s.limb_active && torque_mode == jpdt_pkg::MODE_COMPUTED)
            begin
                gain = fx_mul(longint'(s.peak_torque), inv_limit_margin);
                u = -fx_mul(kp_gain, q - ref_a) - fx_mul(kd_gain, dq - vref);
                if (q + limit_margin >= up)
                begin
                    r.zone = jpdt_pkg::ZONE_UPPER;
                    u -= fx_mul(gain, q - (up - limit_margin));
                end
                else if (q - limit_margin <= lo)
                begin
                    r.zone = jpdt_pkg::ZONE_LOWER;
                    u += fx_mul(gain, (lo + limit_margin) - q);
                end
                if (u > 64'sd2147483647)
                begin
                    u = 64'sd2147483647;
                    r.saturated = 1'b1;
                end
                else if (u < -64'sd2147483648)
                begin
                    u = -64'sd2147483648;
                    r.saturated = 1'b1;
                end
                r.torque = u[31:0];
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [jpdt_pkg::OUT_DATA_W-1:0] word);
            torque_result_t want;
            torque_result_t got;
            got.torque    = word[31:0];
            got.angle     = word[63:32];
            got.zone      = word[65:64];
            got.saturated = word[66];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result, actual torque=%0d angle=%0d zone=%0d sat=%0b",
                             $time, $signed(got.torque), $signed(got.angle), got.zone,
                             got.saturated);
                return;
            end
            want = pending_results.pop_front();
            if (got.torque !== want.torque || got.angle !== want.angle ||
                got.zone !== want.zone || got.saturated !== want.saturated)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: expected torque=%0d angle=%0d zone=%0d sat=%0b, %s%0d%s%0d%s%0d%s%0b",
                             $time, $signed(want.torque), $signed(want.angle), want.zone,
                             want.saturated, "actual torque=", $signed(got.torque),
                             " angle=", $signed(got.angle), " zone=", got.zone,
                             " sat=", got.saturated);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined joint PD torque controller.
// Samples go in on the input stream while a scoreboard predicts each torque
// command; results are compared field by field, in order, as they come out.
// The run walks through several register settings and handshake idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import jpdt_tb_pkg::*;

    localparam int Q_ONE        = 65536;
    localparam int S32_MAX      = 32'sh7FFF_FFFF;
    localparam int S32_MIN      = 32'sh8000_0000;
    localparam int ITEMS_PHASE  = 150;
    localparam int LIMIT_CYCLES = 500000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // angle_ref, angle_meas, velocity_meas, upper_limit, lower_limit,
    // peak_torque, limb_active (lowest bits first)
    logic [jpdt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // joint_index
    logic [jpdt_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;

    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    // torque_out, angle_out, limit_zone, saturated, zero fill (lowest first)
    logic [jpdt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [jpdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]                     cfg_data = '0;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int                              send_idle_pct = 0;
    int                              recv_stall_pct = 0;
    int                              cycle_count = 0;

    // Last reference angle handed to each joint, so that well-formed samples
    // follow a slow trajectory and give sensible reference velocities.
    logic signed [31:0]              ref_track [JOINT_COUNT];

    torque_scoreboard                board;

    joint_pd_torque_with_limit_avoid_top #(
        .MAX_JOINTS (JOINT_COUNT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. Hitting this limit means the block has stopped moving transfers.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("joint_pd_torque_with_limit_avoid_top: mismatch");
            $finish;
        end
    end

    // Result side. Signals read right after the edge still hold the values
    // that the edge sampled, so a transfer is seen exactly once. The ready
    // for the next cycle is then redrawn from the current stall rate.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offers one sample and returns at the edge that transfers it. Valid is
    // left high so that back-to-back samples need no dead cycle.
    task automatic send_sample(input joint_sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.limb_active, s.peak_torque, s.lower_limit, s.upper_limit,
                          s.velocity_meas, s.angle_meas, s.angle_ref};
        s_axis_tuser  <= s.joint;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(s);
    endtask

    // Register write; valid stays up so that a batch of writes runs back to back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.store_register(idx, data);
    endtask

    task automatic configure(input logic [31:0] kp, input logic [31:0] kd,
                             input logic [31:0] invp, input logic [31:0] margin,
                             input logic [31:0] inv_margin, input logic [31:0] mode);
        write_reg(jpdt_pkg::CFG_KP_GAIN, kp);
        write_reg(jpdt_pkg::CFG_KD_GAIN, kd);
        write_reg(jpdt_pkg::CFG_INV_PERIOD, invp);
        write_reg(jpdt_pkg::CFG_LIMIT_MARGIN, margin);
        write_reg(jpdt_pkg::CFG_INV_LIMIT_MARGIN, inv_margin);
        write_reg(jpdt_pkg::CFG_TORQUE_MODE, mode);
        cfg_valid <= 1'b0;
    endtask

    // Every sample yields one result, so an empty scoreboard queue means an
    // empty pipeline as well.
    task automatic wait_drain();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic joint_sample_t mk(input logic [5:0] joint, input int angle_ref,
                                         input int q, input int dq, input int up,
                                         input int lo, input logic [30:0] peak,
                                         input logic active);
        joint_sample_t s;
        s.joint         = joint;
        s.angle_ref     = angle_ref;
        s.angle_meas    = q;
        s.velocity_meas = dq;
        s.upper_limit   = up;
        s.lower_limit   = lo;
        s.peak_torque   = peak;
        s.limb_active   = active;
        return s;
    endfunction

    // Most samples are plausible joint states: limits around the origin, a
    // slowly moving reference on a handful of joints and a measured angle near
    // the reference or near one of the limits. The rest is raw noise.
    function automatic joint_sample_t random_sample();
        joint_sample_t s;
        int            step;
        if ($urandom_range(0, 99) < 15)
        begin
            s.joint         = 6'($urandom);
            s.angle_ref     = $urandom;
            s.angle_meas    = $urandom;
            s.velocity_meas = $urandom;
            s.upper_limit   = $urandom;
            s.lower_limit   = $urandom;
            s.peak_torque   = 31'($urandom);
            s.limb_active   = 1'($urandom_range(0, 1));
            return s;
        end
        if ($urandom_range(0, 99) < 80)
            s.joint = 6'($urandom_range(0, 7));
        else
            s.joint = 6'($urandom_range(0, JOINT_COUNT - 1));
        step = int'($urandom_range(0, 4000)) - 2000;
        s.angle_ref = ref_track[s.joint] + step;
        ref_track[s.joint] = s.angle_ref;
        s.upper_limit = int'($urandom_range(Q_ONE / 2, 4 * Q_ONE));
        s.lower_limit = -int'($urandom_range(Q_ONE / 2, 4 * Q_ONE));
        case ($urandom_range(0, 2))
            0: s.angle_meas = s.angle_ref + int'($urandom_range(0, 6000)) - 3000;
            1: s.angle_meas = s.upper_limit + int'($urandom_range(0, 20000)) - 12000;
            default: s.angle_meas = s.lower_limit + int'($urandom_range(0, 20000)) - 8000;
        endcase
        s.velocity_meas = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        s.peak_torque   = 31'($urandom_range(0, 300 * Q_ONE));
        s.limb_active   = ($urandom_range(0, 9) != 0);
        return s;
    endfunction

    // Edge cases at reset register values: first and repeated samples of a
    // joint, extreme field values, both zone boundaries on each side, limits
    // that overlap, inactive limbs and both saturation rails.
    task automatic run_directed();
        int m;
        m = int'(jpdt_pkg::RST_LIMIT_MARGIN);
        send_sample(mk(6'd0, 0, 0, 0, 0, 0, 31'd0, 1'b1));
        send_sample(mk(6'd0, Q_ONE, 0, 0, 3 * Q_ONE, -3 * Q_ONE, 31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd0, 0, 0, 0, 3 * Q_ONE, -3 * Q_ONE, 31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd63, S32_MAX, S32_MIN, S32_MAX, S32_MAX, S32_MIN, '1, 1'b1));
        send_sample(mk(6'd63, S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 31'd0, 1'b0));
        send_sample(mk(6'd63, S32_MIN, 0, 0, 3 * Q_ONE, -3 * Q_ONE, 31'(Q_ONE), 1'b1));
        send_sample(mk(6'd1, 3 * Q_ONE - 100, 3 * Q_ONE - 100, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd1, 3 * Q_ONE - m, 3 * Q_ONE - m, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd1, 3 * Q_ONE - m - 1, 3 * Q_ONE - m - 1, 0, 3 * Q_ONE,
                       -3 * Q_ONE, 31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd2, -3 * Q_ONE + 100, -3 * Q_ONE + 100, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd2, -3 * Q_ONE + m, -3 * Q_ONE + m, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd2, -3 * Q_ONE + m + 1, -3 * Q_ONE + m + 1, 0, 3 * Q_ONE,
                       -3 * Q_ONE, 31'(10 * Q_ONE), 1'b1));
        // Overlapping limits: the upper zone takes precedence.
        send_sample(mk(6'd3, 0, 0, 0, 0, 0, 31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd3, 0, 20000 * Q_ONE, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd4, 0, -20000 * Q_ONE, 0, 3 * Q_ONE, -3 * Q_ONE,
                       31'(10 * Q_ONE), 1'b1));
        send_sample(mk(6'd4, 0, 3 * Q_ONE, 0, 3 * Q_ONE, -3 * Q_ONE, 31'(10 * Q_ONE), 1'b0));
        send_sample(mk(6'd5, Q_ONE, Q_ONE + Q_ONE / 2, Q_ONE / 4, 3 * Q_ONE, -3 * Q_ONE,
                       31'(Q_ONE), 1'b1));
        send_sample(mk(6'd5, Q_ONE, 4 * Q_ONE, 0, Q_ONE, -3 * Q_ONE, '1, 1'b1));
        send_sample(mk(6'd6, 0, 0, S32_MIN, 3 * Q_ONE, -3 * Q_ONE, 31'(Q_ONE), 1'b1));
        send_sample(mk(6'd6, 0, 0, S32_MAX, 3 * Q_ONE, -3 * Q_ONE, 31'(Q_ONE), 1'b1));
    endtask

    // Random samples; with_pause makes the sender stop halfway until the
    // pipeline has emptied, then carry on.
    task automatic run_random(input int count, input bit with_pause);
        for (int i = 0; i < count; i++)
        begin
            send_sample(random_sample());
            if (with_pause && i == count / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drain();
            end
        end
    endtask

    initial
    begin
        logic [31:0] margin;
        board = new();
        foreach (ref_track[i])
            ref_track[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Eight phases. Each idle mix (none, sender, receiver, both) is used
        // twice, and every phase but the first runs at a new register setting.
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase

            margin = $urandom_range(0, 20000);
            case (p)
                0: ;
                // Everything at its minimum: no gains, no margin, computed mode.
                1: configure('0, '0, '0, '0, '0, 32'(jpdt_pkg::MODE_COMPUTED));
                // Everything at its maximum; the margin write also carries a set
                // top bit, which lies beyond the register.
                2: configure('1, '1, '1, '1, '1, 32'(jpdt_pkg::MODE_COMPUTED));
                3: configure($urandom_range(0, 3000) << 16, $urandom_range(0, 100) << 16,
                             $urandom_range(100, 2000) << 16, margin,
                             (margin == 0) ? 32'd0 : 32'((64'd1 << 32) / margin),
                             32'(jpdt_pkg::MODE_COMPUTED));
                // Reference torque mode: every command comes out as zero.
                4: configure($urandom_range(0, 3000) << 16, $urandom_range(0, 100) << 16,
                             $urandom_range(100, 2000) << 16, margin,
                             (margin == 0) ? 32'd0 : 32'((64'd1 << 32) / margin),
                             32'(~jpdt_pkg::MODE_COMPUTED));
                5: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), margin, $urandom_range(0, 65535),
                             32'(jpdt_pkg::MODE_COMPUTED));
                6: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: configure(jpdt_pkg::RST_KP_GAIN, jpdt_pkg::RST_KD_GAIN,
                                   jpdt_pkg::RST_INV_PERIOD, 32'(jpdt_pkg::RST_LIMIT_MARGIN),
                                   jpdt_pkg::RST_INV_LIMIT_MARGIN,
                                   32'(jpdt_pkg::RST_TORQUE_MODE));
            endcase

            if (p == 0)
                run_directed();
            run_random(ITEMS_PHASE, p == 2);

            // Registers may only change with nothing in flight.
            s_axis_tvalid <= 1'b0;
            wait_drain();
        end

        // Wait past the pipeline depth so that a stray extra result shows up.
        repeat (jpdt_pkg::STAGES + 4) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("joint_pd_torque_with_limit_avoid_top: match");
        else
            $display("joint_pd_torque_with_limit_avoid_top: mismatch");
        $finish;
    end

endmodule
